// ----- rtl/xtea_pkg.sv -----
package xtea_pkg;

    localparam int CYCLE_COUNT = 32;
    localparam int HALF_W      = 32;
    localparam int KEY_WORDS   = 4;
    localparam int CFG_INDEX_W = 3;

    localparam logic [HALF_W-1:0] DELTA = 32'h9E37_79B9;

    // key word selection: low bits of sum, or bits starting at SUM_SHIFT
    localparam int SUM_SHIFT = 11;

    localparam logic CMD_ENCRYPT = 1'b0;
    localparam logic CMD_DECRYPT = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD0 = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD1 = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD2 = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD3 = 3'd3;

    typedef logic [KEY_WORDS-1:0][HALF_W-1:0] key_t;

    typedef struct packed {
        logic              cmd;
        logic [HALF_W-1:0] first;
        logic [HALF_W-1:0] second;
    } block_t;

    // delta * n modulo 2^32, used for elaboration-time constants only
    function automatic logic [HALF_W-1:0] round_sum(input int n);
        logic [63:0] prod;
        prod = 64'(DELTA) * 64'(n);
        return prod[HALF_W-1:0];
    endfunction

    function automatic logic [HALF_W-1:0] mix(input logic [HALF_W-1:0] x);
        return ((x << 4) ^ (x >> 5)) + x;
    endfunction

endpackage

// ----- rtl/xtea_stage.sv -----
// One half-round of XTEA, registered. Even stages of a round touch the
// first half on encrypt and the second half on decrypt; odd stages the other.
module xtea_stage #(
    parameter int ROUND       = 0,
    parameter bit SECOND_HALF = 1'b0,
    parameter int CYCLES      = xtea_pkg::CYCLE_COUNT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  xtea_pkg::block_t in_blk,
    input  xtea_pkg::key_t  key,
    output logic            out_valid,
    output xtea_pkg::block_t out_blk
);

    localparam logic [xtea_pkg::HALF_W-1:0] ENC_SUM =
        xtea_pkg::round_sum(SECOND_HALF ? ROUND + 1 : ROUND);
    localparam logic [xtea_pkg::HALF_W-1:0] DEC_SUM =
        xtea_pkg::round_sum(SECOND_HALF ? CYCLES - ROUND - 1 : CYCLES - ROUND);
    localparam logic [1:0] ENC_KEY_IDX = SECOND_HALF ?
        ENC_SUM[xtea_pkg::SUM_SHIFT+1:xtea_pkg::SUM_SHIFT] : ENC_SUM[1:0];
    localparam logic [1:0] DEC_KEY_IDX = SECOND_HALF ?
        DEC_SUM[1:0] : DEC_SUM[xtea_pkg::SUM_SHIFT+1:xtea_pkg::SUM_SHIFT];

    logic                         valid_reg;
    xtea_pkg::block_t             blk_reg;
    xtea_pkg::block_t             blk_next;
    logic                         decrypt;
    logic                         upd_first;
    logic [xtea_pkg::HALF_W-1:0]  src;
    logic [xtea_pkg::HALF_W-1:0]  target;
    logic [xtea_pkg::HALF_W-1:0]  sum;
    logic [1:0]                   key_idx;
    logic [xtea_pkg::HALF_W-1:0]  term;
    logic [xtea_pkg::HALF_W-1:0]  result;

    always_comb
    begin
        decrypt   = (in_blk.cmd == xtea_pkg::CMD_DECRYPT);
        upd_first = (decrypt == SECOND_HALF);
        src       = upd_first ? in_blk.second : in_blk.first;
        target    = upd_first ? in_blk.first : in_blk.second;
        sum       = decrypt ? DEC_SUM : ENC_SUM;
        key_idx   = decrypt ? DEC_KEY_IDX : ENC_KEY_IDX;
        term      = xtea_pkg::mix(src) ^ (sum + key[key_idx]);
        result    = decrypt ? (target - term) : (target + term);
        blk_next  = in_blk;
        if (upd_first)
        begin
            blk_next.first = result;
        end
        else
        begin
            blk_next.second = result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            blk_reg <= blk_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_blk   = blk_reg;

endmodule

// ----- rtl/xtea_block_cipher_core.sv -----
// Channel  Handshake             Payload
// -------  --------------------  ------------------------------------
// in       in_valid / in_ready   command, block_first, block_second
// out      out_valid / out_ready out_first, out_second
// cfg      cfg_write_en          cfg_index, cfg_data (key words 0..3)
//
// One block per cycle while out is not stalled; one stage per half-round.
// The whole pipeline advances together when the last stage is empty or taken.
// Reset clears stage valid bits and the key words; no clearing pass.
// A stall on out holds every stage and drops in_ready the same cycle.
module xtea_block_cipher_core #(
    parameter int CYCLE_COUNT = xtea_pkg::CYCLE_COUNT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                command,
    input  logic [xtea_pkg::HALF_W-1:0]         block_first,
    input  logic [xtea_pkg::HALF_W-1:0]         block_second,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [xtea_pkg::HALF_W-1:0]         out_first,
    output logic [xtea_pkg::HALF_W-1:0]         out_second,
    input  logic                                cfg_write_en,
    input  logic [xtea_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [xtea_pkg::HALF_W-1:0]         cfg_data
);

    localparam int STAGES = 2 * CYCLE_COUNT;

    xtea_pkg::key_t    key_reg;
    logic              en;
    logic              stage_valid [STAGES];
    xtea_pkg::block_t  stage_blk   [STAGES];
    xtea_pkg::block_t  in_blk;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                xtea_pkg::REG_KEY_WORD0: key_reg[0] <= cfg_data;
                xtea_pkg::REG_KEY_WORD1: key_reg[1] <= cfg_data;
                xtea_pkg::REG_KEY_WORD2: key_reg[2] <= cfg_data;
                xtea_pkg::REG_KEY_WORD3: key_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    assign en       = !stage_valid[STAGES-1] || out_ready;
    assign in_ready = en;

    always_comb
    begin
        in_blk.cmd    = command;
        in_blk.first  = block_first;
        in_blk.second = block_second;
    end

    for (genvar i = 0; i < STAGES; i++)
    begin : g_stage
        if (i == 0)
        begin : g_head
            xtea_stage #(
                .ROUND       (i / 2),
                .SECOND_HALF (1'b0),
                .CYCLES      (CYCLE_COUNT)
            ) u_stage (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (en),
                .in_valid  (in_valid),
                .in_blk    (in_blk),
                .key       (key_reg),
                .out_valid (stage_valid[i]),
                .out_blk   (stage_blk[i])
            );
        end
        else
        begin : g_body
            xtea_stage #(
                .ROUND       (i / 2),
                .SECOND_HALF ((i % 2) == 1),
                .CYCLES      (CYCLE_COUNT)
            ) u_stage (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (en),
                .in_valid  (stage_valid[i-1]),
                .in_blk    (stage_blk[i-1]),
                .key       (key_reg),
                .out_valid (stage_valid[i]),
                .out_blk   (stage_blk[i])
            );
        end
    end

    assign out_valid  = stage_valid[STAGES-1];
    assign out_first  = stage_blk[STAGES-1].first;
    assign out_second = stage_blk[STAGES-1].second;

endmodule

// ----- rtl/xtea_checker.sv -----
module xtea_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [xtea_pkg::HALF_W-1:0] out_first,
    input logic [xtea_pkg::HALF_W-1:0] out_second
);

    // held result must not move while the sink stalls
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_first) && $stable(out_second))
        else $error("result changed while stalled");

    // empty output slot means the pipeline can always take a transaction
    a_free_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    a_flow_through: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input stalled while output drains");

    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result shown during reset");

    // a stall on the input must come from a stalled output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output back-pressure");

endmodule

bind xtea_block_cipher_core xtea_checker u_xtea_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_first  (out_first),
    .out_second (out_second)
);

// ----- tb/sv/xtea_cipher_checker.sv -----
module xtea_cipher_checker
    import xtea_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic              command,
    input  logic [HALF_W-1:0] block_first,
    input  logic [HALF_W-1:0] block_second,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic [HALF_W-1:0] out_first,
    input  logic [HALF_W-1:0] out_second,
    input  logic              cfg_write_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [HALF_W-1:0] cfg_data,
    output int                mismatches,
    output int                blocks_in_flight
);

    typedef struct packed {
        logic [HALF_W-1:0] first;
        logic [HALF_W-1:0] second;
    } halves_t;

    key_t    cipher_key;
    halves_t transformed_due[$];
    halves_t oldest;

    function automatic logic [HALF_W-1:0] feistel_term(input logic [HALF_W-1:0] x);
        return ((x << 4) ^ (x >> 5)) + x;
    endfunction

    function automatic halves_t xtea_transform(
        input logic              cmd,
        input logic [HALF_W-1:0] a,
        input logic [HALF_W-1:0] b,
        input key_t              k
    );
        logic [HALF_W-1:0] v0;
        logic [HALF_W-1:0] v1;
        logic [HALF_W-1:0] sum;
        int                n;
        v0  = a;
        v1  = b;
        sum = '0;
        if (cmd == CMD_ENCRYPT)
        begin
            for (n = 0; n < CYCLE_COUNT; n++)
            begin
                v0  += feistel_term(v1) ^ (sum + k[sum[1:0]]);
                sum += DELTA;
                v1  += feistel_term(v0) ^ (sum + k[sum[SUM_SHIFT +: 2]]);
            end
        end
        else
        begin
            // start from delta times the round count, wrapping at 2^32
            for (n = 0; n < CYCLE_COUNT; n++)
                sum += DELTA;
            for (n = 0; n < CYCLE_COUNT; n++)
            begin
                v1  -= feistel_term(v0) ^ (sum + k[sum[SUM_SHIFT +: 2]]);
                sum -= DELTA;
                v0  -= feistel_term(v1) ^ (sum + k[sum[1:0]]);
            end
        end
        return '{first: v0, second: v1};
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cipher_key = '0;
            transformed_due.delete();
            mismatches = 0;
            blocks_in_flight = 0;
        end
        else
        begin
            // indexes past the last key word are dropped by the block
            if (cfg_write_en && cfg_index < KEY_WORDS)
                cipher_key[cfg_index[1:0]] = cfg_data;

            if (out_valid && out_ready)
            begin
                if (transformed_due.size() == 0)
                begin
                    $error("unexpected transaction: out_first %h out_second %h",
                           out_first, out_second);
                    mismatches++;
                end
                else
                begin
                    oldest = transformed_due.pop_front();
                    if (out_first !== oldest.first)
                    begin
                        $error("out_first: expected %h, actual %h", oldest.first, out_first);
                        mismatches++;
                    end
                    if (out_second !== oldest.second)
                    begin
                        $error("out_second: expected %h, actual %h",
                               oldest.second, out_second);
                        mismatches++;
                    end
                end
            end

            if (in_valid && in_ready)
                transformed_due.push_back(
                    xtea_transform(command, block_first, block_second, cipher_key));

            blocks_in_flight = transformed_due.size();
        end
    end

endmodule

// ----- tb/sv/xtea_block_cipher_core_test.sv -----
module xtea_block_cipher_core_test;

    import xtea_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int TIMEOUT_CYCLES = 500_000;
    localparam int PHASE_BLOCKS   = 100;
    localparam int HOLD_OFF       = 300;
    localparam int HOLD_OFF_AFTER = 150;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic                   command;
    logic [HALF_W-1:0]      block_first;
    logic [HALF_W-1:0]      block_second;
    logic                   out_valid;
    logic                   out_ready;
    logic [HALF_W-1:0]      out_first;
    logic [HALF_W-1:0]      out_second;
    logic                   cfg_write_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [HALF_W-1:0]      cfg_data;

    int mismatches;
    int blocks_in_flight;
    int blocks_accepted;
    bit calm;
    bit hold_off_done;

    logic [HALF_W-1:0] corner_first [5];
    logic [HALF_W-1:0] corner_second[5];

    xtea_block_cipher_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .block_first  (block_first),
        .block_second (block_second),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_first    (out_first),
        .out_second   (out_second),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    xtea_cipher_checker i_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .command          (command),
        .block_first      (block_first),
        .block_second     (block_second),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .out_first        (out_first),
        .out_second       (out_second),
        .cfg_write_en     (cfg_write_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .mismatches       (mismatches),
        .blocks_in_flight (blocks_in_flight)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    function automatic logic [HALF_W-1:0] pick_half();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic offer_block(input logic cmd, input logic [HALF_W-1:0] a,
                               input logic [HALF_W-1:0] b);
        int gap;
        gap = sender_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        command      <= cmd;
        block_first  <= a;
        block_second <= b;
        in_valid     <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        blocks_accepted++;
        @(negedge clk);
    endtask

    // leaves the write enable high; the caller drops it after the last write
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [HALF_W-1:0] val);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= val;
        @(negedge clk);
    endtask

    task automatic load_key(input logic [HALF_W-1:0] k0, input logic [HALF_W-1:0] k1,
                            input logic [HALF_W-1:0] k2, input logic [HALF_W-1:0] k3);
        write_reg(REG_KEY_WORD0, k0);
        write_reg(REG_KEY_WORD1, k1);
        write_reg(REG_KEY_WORD2, k2);
        write_reg(REG_KEY_WORD3, k3);
        // an index past the key words must leave the key alone
        write_reg(CFG_INDEX_W'($urandom_range(KEY_WORDS, 2**CFG_INDEX_W - 1)), $urandom);
        cfg_write_en <= 1'b0;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (blocks_in_flight != 0)
            @(negedge clk);
    endtask

    task automatic corner_blocks();
        int i;
        for (i = 0; i < 5; i++)
        begin
            offer_block(CMD_ENCRYPT, corner_first[i], corner_second[i]);
            offer_block(CMD_DECRYPT, corner_first[i], corner_second[i]);
        end
    endtask

    // receiver: random stalls, plus one long hold-off so the pipeline backs up
    initial
    begin
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (!hold_off_done && blocks_accepted >= HOLD_OFF_AFTER)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_OFF) @(negedge clk);
                hold_off_done = 1'b1;
            end
            else if (calm || $urandom_range(0, 3) != 0)
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(negedge clk);
            end
            else
            begin
                out_ready <= 1'b0;
                if ($urandom_range(0, 9) == 0)
                    repeat ($urandom_range(20, 60)) @(negedge clk);
                else
                    repeat ($urandom_range(1, 4)) @(negedge clk);
            end
        end
    end

    initial
    begin
        #(TIMEOUT_CYCLES * 2 * CLK_HALF);
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        int ph;
        int n;
        clk             = 1'b0;
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        command         = CMD_ENCRYPT;
        block_first     = '0;
        block_second    = '0;
        out_ready       = 1'b0;
        cfg_write_en    = 1'b0;
        cfg_index       = REG_KEY_WORD0;
        cfg_data        = '0;
        blocks_accepted = 0;
        calm            = 1'b0;
        hold_off_done   = 1'b0;

        corner_first  = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000};
        corner_second = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001};

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // all-zero key straight out of reset, then all-ones key
        corner_blocks();
        drain();
        load_key('1, '1, '1, '1);
        corner_blocks();
        drain();

        for (ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:       load_key($urandom, $urandom, $urandom, $urandom);
                1:       load_key('0, '1, '0, '1);
                default: load_key(pick_half(), pick_half(), pick_half(), pick_half());
            endcase
            calm = (ph == 2);
            for (n = 0; n < PHASE_BLOCKS; n++)
                offer_block(logic'($urandom_range(0, 1)), pick_half(), pick_half());
            drain();
        end
        calm = 1'b0;

        repeat (2 * CYCLE_COUNT + 8) @(negedge clk);
        if (mismatches == 0 && blocks_in_flight == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
